/* sv/rkv_pkg.sv */
// Shared types, constants and the derivative microcode for the two-strain RK4 core.
// Used by every module in this folder; depends on nothing else.
package rkv_pkg;

	localparam int VALUE_WIDTH = 24;
	localparam int FRAC_BITS   = 20;
	localparam int IO_WIDTH    = 24;
	localparam int RATE_BITS   = 24;
	localparam int SLOPE_WIDTH = VALUE_WIDTH + 4;
	localparam int ACC_WIDTH   = VALUE_WIDTH + 3;
	localparam int OPD_WIDTH   = RATE_BITS + 1;
	localparam int MUL_WIDTH   = 32;
	localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
	localparam int STEP_WIDTH  = 16;
	localparam int NUM_VARS    = 6;
	localparam int NUM_PAIRS   = 6;
	localparam int NUM_RATES   = 12;
	localparam int NUM_UOPS    = 30;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 2 * RATE_BITS;
	localparam int RECIP_SHIFT = 34;

	// Division by six as a multiplication: exact for any 32-bit dividend.
	localparam logic [MUL_WIDTH-1:0] RECIP_SIX = 32'hAAAA_AAAB;

	localparam logic signed [VALUE_WIDTH-1:0] ONE_VALUE =
		(FRAC_BITS < VALUE_WIDTH - 1) ? VALUE_WIDTH'(64'd1 << FRAC_BITS)
		                              : VALUE_WIDTH'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

	localparam logic [RATE_BITS-1:0]  STEP_SIZE_RESET  = 24'd104858;
	localparam logic [STEP_WIDTH-1:0] STEP_COUNT_RESET = 16'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_INFECT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROWTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOSS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BINDING    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 3'd7;

	localparam logic [1:0] LAST_STAGE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_WB,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MODE_F,
		MODE_F1,
		MODE_Q,
		MODE_DIV6
	} mul_mode_t;

	typedef enum logic [4:0] {
		SRC_X0, SRC_X1, SRC_X2, SRC_X3, SRC_X4, SRC_X5,
		SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5,
		SRC_R6, SRC_R7, SRC_R8, SRC_R9, SRC_R10, SRC_R11,
		SRC_TU, SRC_TV, SRC_TB0, SRC_TB1, SRC_TP, SRC_ONE
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_TU, DST_TV, DST_TB0, DST_TB1, DST_TP,
		DST_K0, DST_K1, DST_K2, DST_K3, DST_K4, DST_K5
	} dst_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_SET,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic    is_mul;
		src_t    a;
		src_t    b;
		acc_op_t acc;
		dst_t    dst;
	} uop_t;

	typedef struct packed {
		logic       load;
		logic       issue;
		logic       wb;
		logic       finish;
		logic       lanes;
		logic [2:0] lane;
		logic       pass;
		logic [1:0] stage;
		logic [4:0] pc;
	} ctl_t;

	function automatic uop_t mk(input logic m, input src_t a, input src_t b,
	                            input acc_op_t acc, input dst_t dst);
		uop_t u;
		u.is_mul = m;
		u.a      = a;
		u.b      = b;
		u.acc    = acc;
		u.dst    = dst;
		return u;
	endfunction

	// One pass over the right-hand side. A product with no accumulate writes the
	// rounded product; every other write takes the saturated accumulator.
	function automatic uop_t uop_rom(input logic [4:0] pc);
		uop_t u;
		u = mk(1'b0, SRC_ONE, SRC_ONE, ACC_NONE, DST_NONE);
		case (pc)
			5'd0:  u = mk(1'b0, SRC_ONE, SRC_ONE, ACC_SET, DST_NONE);
			5'd1:  u = mk(1'b0, SRC_X0,  SRC_ONE, ACC_SUB, DST_NONE);
			5'd2:  u = mk(1'b0, SRC_X1,  SRC_ONE, ACC_SUB, DST_TU);
			5'd3:  u = mk(1'b0, SRC_ONE, SRC_ONE, ACC_SET, DST_NONE);
			5'd4:  u = mk(1'b0, SRC_X2,  SRC_ONE, ACC_SUB, DST_NONE);
			5'd5:  u = mk(1'b0, SRC_X3,  SRC_ONE, ACC_SUB, DST_TV);
			5'd6:  u = mk(1'b1, SRC_R8,  SRC_X0,  ACC_NONE, DST_TB0);
			5'd7:  u = mk(1'b1, SRC_TB0, SRC_X3,  ACC_NONE, DST_TB0);
			5'd8:  u = mk(1'b1, SRC_R9,  SRC_X1,  ACC_NONE, DST_TB1);
			5'd9:  u = mk(1'b1, SRC_TB1, SRC_X3,  ACC_NONE, DST_TB1);
			5'd10: u = mk(1'b1, SRC_R0,  SRC_X0,  ACC_NONE, DST_TP);
			5'd11: u = mk(1'b1, SRC_TP,  SRC_X2,  ACC_NONE, DST_TP);
			5'd12: u = mk(1'b1, SRC_TP,  SRC_TU,  ACC_SET, DST_NONE);
			5'd13: u = mk(1'b0, SRC_TB0, SRC_ONE, ACC_SUB, DST_NONE);
			5'd14: u = mk(1'b1, SRC_R4,  SRC_X0,  ACC_SUB, DST_K0);
			5'd15: u = mk(1'b1, SRC_R1,  SRC_X1,  ACC_NONE, DST_TP);
			5'd16: u = mk(1'b1, SRC_TP,  SRC_X2,  ACC_NONE, DST_TP);
			5'd17: u = mk(1'b1, SRC_TP,  SRC_TU,  ACC_SET, DST_NONE);
			5'd18: u = mk(1'b0, SRC_TB1, SRC_ONE, ACC_SUB, DST_NONE);
			5'd19: u = mk(1'b1, SRC_R5,  SRC_X1,  ACC_SUB, DST_K1);
			5'd20: u = mk(1'b1, SRC_R2,  SRC_X0,  ACC_NONE, DST_TP);
			5'd21: u = mk(1'b1, SRC_TP,  SRC_TV,  ACC_SET, DST_NONE);
			5'd22: u = mk(1'b1, SRC_R6,  SRC_X2,  ACC_SUB, DST_K2);
			5'd23: u = mk(1'b1, SRC_R3,  SRC_X1,  ACC_NONE, DST_TP);
			5'd24: u = mk(1'b1, SRC_TP,  SRC_TV,  ACC_SET, DST_NONE);
			5'd25: u = mk(1'b1, SRC_R7,  SRC_X3,  ACC_SUB, DST_K3);
			5'd26: u = mk(1'b0, SRC_TB0, SRC_ONE, ACC_SET, DST_NONE);
			5'd27: u = mk(1'b1, SRC_R10, SRC_X4,  ACC_SUB, DST_K4);
			5'd28: u = mk(1'b0, SRC_TB1, SRC_ONE, ACC_SET, DST_NONE);
			5'd29: u = mk(1'b1, SRC_R11, SRC_X5,  ACC_SUB, DST_K5);
			default: u = mk(1'b0, SRC_ONE, SRC_ONE, ACC_NONE, DST_NONE);
		endcase
		return u;
	endfunction

	function automatic logic signed [VALUE_WIDTH-1:0] sat_val(
		input logic signed [ACC_WIDTH-1:0] x);
		logic signed [ACC_WIDTH-1:0] hi;
		logic signed [ACC_WIDTH-1:0] lo;
		hi = {{(ACC_WIDTH - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[VALUE_WIDTH-1:0];
		end else if (x < lo) begin
			return lo[VALUE_WIDTH-1:0];
		end
		return x[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic signed [SLOPE_WIDTH-1:0] sat_slope(
		input logic signed [SLOPE_WIDTH:0] x);
		logic signed [SLOPE_WIDTH:0] hi;
		logic signed [SLOPE_WIDTH:0] lo;
		hi = {2'b00, {(SLOPE_WIDTH - 1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[SLOPE_WIDTH-1:0];
		end else if (x < lo) begin
			return lo[SLOPE_WIDTH-1:0];
		end
		return x[SLOPE_WIDTH-1:0];
	endfunction

endpackage

/* sv/rk4_two_strain_virus_ode_core.sv */
// Top level of the two-strain virus RK4 integrator: state, operand selection, handshakes.
// Depends on rkv_pkg, rkv_seq and rkv_mul_unit.
//
// Usage. Eight configuration registers are written through cfg_write_en, cfg_index
// and cfg_data while the core is idle; six rate pairs, the step size and the step
// count. An input beat carries one initial state of six signed values and is taken
// when in_valid is high and in_stall low. The core then runs step_count fourth-order
// Runge-Kutta steps and presents the six final values as one output beat, held
// until out_stall is low.
// Datapath. All arithmetic goes through one shared multiplier with a registered
// product, so every micro-operation passes through an issue state and a write-back
// state. A step is four right-hand-side passes of 30 micro-operations plus the
// per-variable updates, and a check of the remaining step count. in_stall is high
// from acceptance until the result moves to the output register.
// The finished result sits in an output register, so a new input beat is taken
// while the previous result still waits on a stalled receiver; the core only
// waits at the end of a run if that register is still full.
// Reset clears the sequencer and the output valid and sets the configuration
// registers to their reset values; no beat is in flight afterwards.
module rk4_two_strain_virus_ode_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write_en,
	input  logic [rkv_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rkv_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0]    init_first_strain,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0]    init_second_strain,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0]    init_first_helper,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0]    init_shared_pool,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0]    init_first_complex,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0]    init_second_complex,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rkv_pkg::IO_WIDTH-1:0]    final_first_strain,
	output logic signed [rkv_pkg::IO_WIDTH-1:0]    final_second_strain,
	output logic signed [rkv_pkg::IO_WIDTH-1:0]    final_first_helper,
	output logic signed [rkv_pkg::IO_WIDTH-1:0]    final_shared_pool,
	output logic signed [rkv_pkg::IO_WIDTH-1:0]    final_first_complex,
	output logic signed [rkv_pkg::IO_WIDTH-1:0]    final_second_complex
);

	localparam int VW = rkv_pkg::VALUE_WIDTH;
	localparam int SW = rkv_pkg::SLOPE_WIDTH;
	localparam int AW = rkv_pkg::ACC_WIDTH;
	localparam int OW = rkv_pkg::OPD_WIDTH;
	localparam int MW = rkv_pkg::MUL_WIDTH;
	localparam int NV = rkv_pkg::NUM_VARS;

	logic [rkv_pkg::CFG_DATA_W-1:0] pair_q [rkv_pkg::NUM_PAIRS];
	logic [rkv_pkg::RATE_BITS-1:0]  step_size_q;
	logic [rkv_pkg::STEP_WIDTH-1:0] step_count_q;

	logic signed [VW-1:0] cur_q   [NV];
	logic signed [VW-1:0] probe_q [NV];
	logic signed [VW-1:0] k_q     [NV];
	logic signed [SW-1:0] slope_q [NV];
	logic signed [VW-1:0] tu_q, tv_q, tb0_q, tb1_q, tp_q;
	logic signed [AW-1:0] acc_q;
	logic [MW-1:0]        q_q;

	logic                 out_valid_q;
	logic signed [VW-1:0] out_q [NV];

	logic [rkv_pkg::RATE_BITS-1:0] rate_v [rkv_pkg::NUM_RATES];
	logic signed [VW-1:0]          xv     [NV];
	logic signed [OW-1:0]          opd    [2];
	rkv_pkg::src_t                 sel    [2];

	rkv_pkg::ctl_t      ctl;
	rkv_pkg::uop_t      uop;
	logic               busy;
	logic               out_free;
	logic [MW-1:0]      a_mag, b_mag;
	logic               neg;
	rkv_pkg::mul_mode_t mode;
	logic signed [VW-1:0] unit_res;
	logic [MW-1:0]        unit_quot;

	logic signed [OW-1:0]   kl_abs;
	logic signed [SW-1:0]   slope_fin;
	logic [SW-1:0]          slope_abs;
	logic signed [AW-1:0]   r_ext;
	logic signed [AW-1:0]   acc_new;
	logic signed [VW-1:0]   wr_val;
	logic signed [AW-1:0]   lane_sum;

	genvar gi;

	generate
		for (gi = 0; gi < rkv_pkg::NUM_RATES; gi++) begin : g_rate
			assign rate_v[gi] =
				pair_q[gi / 2][(gi % 2) * rkv_pkg::RATE_BITS +: rkv_pkg::RATE_BITS];
		end
	endgenerate

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy;

	rkv_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.out_free   (out_free),
		.step_count (step_count_q),
		.busy       (busy),
		.ctl        (ctl)
	);

	assign uop = rkv_pkg::uop_rom(ctl.pc);

	always_comb begin
		for (int i = 0; i < NV; i++) begin
			xv[i] = (ctl.stage == 2'd0) ? cur_q[i] : probe_q[i];
		end
		sel[0] = uop.a;
		sel[1] = uop.b;
		for (int j = 0; j < 2; j++) begin
			case (sel[j])
				rkv_pkg::SRC_X0:  opd[j] = OW'(xv[0]);
				rkv_pkg::SRC_X1:  opd[j] = OW'(xv[1]);
				rkv_pkg::SRC_X2:  opd[j] = OW'(xv[2]);
				rkv_pkg::SRC_X3:  opd[j] = OW'(xv[3]);
				rkv_pkg::SRC_X4:  opd[j] = OW'(xv[4]);
				rkv_pkg::SRC_X5:  opd[j] = OW'(xv[5]);
				rkv_pkg::SRC_R0:  opd[j] = $signed({1'b0, rate_v[0]});
				rkv_pkg::SRC_R1:  opd[j] = $signed({1'b0, rate_v[1]});
				rkv_pkg::SRC_R2:  opd[j] = $signed({1'b0, rate_v[2]});
				rkv_pkg::SRC_R3:  opd[j] = $signed({1'b0, rate_v[3]});
				rkv_pkg::SRC_R4:  opd[j] = $signed({1'b0, rate_v[4]});
				rkv_pkg::SRC_R5:  opd[j] = $signed({1'b0, rate_v[5]});
				rkv_pkg::SRC_R6:  opd[j] = $signed({1'b0, rate_v[6]});
				rkv_pkg::SRC_R7:  opd[j] = $signed({1'b0, rate_v[7]});
				rkv_pkg::SRC_R8:  opd[j] = $signed({1'b0, rate_v[8]});
				rkv_pkg::SRC_R9:  opd[j] = $signed({1'b0, rate_v[9]});
				rkv_pkg::SRC_R10: opd[j] = $signed({1'b0, rate_v[10]});
				rkv_pkg::SRC_R11: opd[j] = $signed({1'b0, rate_v[11]});
				rkv_pkg::SRC_TU:  opd[j] = OW'(tu_q);
				rkv_pkg::SRC_TV:  opd[j] = OW'(tv_q);
				rkv_pkg::SRC_TB0: opd[j] = OW'(tb0_q);
				rkv_pkg::SRC_TB1: opd[j] = OW'(tb1_q);
				rkv_pkg::SRC_TP:  opd[j] = OW'(tp_q);
				default:          opd[j] = OW'(rkv_pkg::ONE_VALUE);
			endcase
		end
	end

	// Operands for the shared unit: derivative products, probe increments or the
	// two passes of the final weighted update.
	always_comb begin
		kl_abs    = OW'(k_q[ctl.lane]);
		kl_abs    = kl_abs[OW-1] ? -kl_abs : kl_abs;
		slope_fin = rkv_pkg::sat_slope((SW + 1)'(slope_q[ctl.lane])
		                               + (SW + 1)'(k_q[ctl.lane]));
		slope_abs = slope_fin[SW-1] ? $unsigned(-slope_fin) : $unsigned(slope_fin);
		a_mag = MW'($unsigned(opd[0][OW-1] ? -opd[0] : opd[0]));
		b_mag = MW'($unsigned(opd[1][OW-1] ? -opd[1] : opd[1]));
		neg   = opd[0][OW-1] ^ opd[1][OW-1];
		mode  = rkv_pkg::MODE_F;
		if (ctl.lanes) begin
			if (ctl.stage != rkv_pkg::LAST_STAGE) begin
				a_mag = MW'(step_size_q);
				b_mag = MW'($unsigned(kl_abs));
				neg   = k_q[ctl.lane][VW-1];
				mode  = (ctl.stage == 2'd2) ? rkv_pkg::MODE_F : rkv_pkg::MODE_F1;
			end else if (!ctl.pass) begin
				a_mag = MW'(slope_abs);
				b_mag = MW'(step_size_q);
				neg   = 1'b0;
				mode  = rkv_pkg::MODE_Q;
			end else begin
				a_mag = q_q;
				b_mag = rkv_pkg::RECIP_SIX;
				neg   = slope_q[ctl.lane][SW-1];
				mode  = rkv_pkg::MODE_DIV6;
			end
		end
	end

	rkv_mul_unit u_mul (
		.clk   (clk),
		.a_mag (a_mag),
		.b_mag (b_mag),
		.neg   (neg),
		.mode  (mode),
		.res   (unit_res),
		.quot  (unit_quot)
	);

	always_comb begin
		r_ext = uop.is_mul ? AW'(unit_res) : AW'(opd[0]);
		case (uop.acc)
			rkv_pkg::ACC_SET: acc_new = r_ext;
			rkv_pkg::ACC_ADD: acc_new = acc_q + r_ext;
			rkv_pkg::ACC_SUB: acc_new = acc_q - r_ext;
			default:          acc_new = acc_q;
		endcase
		wr_val   = (uop.acc == rkv_pkg::ACC_NONE) ? unit_res : rkv_pkg::sat_val(acc_new);
		lane_sum = AW'(cur_q[ctl.lane]) + AW'(unit_res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rkv_pkg::NUM_PAIRS; i++) begin
				pair_q[i] <= '0;
			end
			step_size_q  <= rkv_pkg::STEP_SIZE_RESET;
			step_count_q <= rkv_pkg::STEP_COUNT_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == rkv_pkg::CFG_STEP_SIZE) begin
				step_size_q <= cfg_data[rkv_pkg::RATE_BITS-1:0];
			end else if (cfg_index == rkv_pkg::CFG_STEP_COUNT) begin
				step_count_q <= cfg_data[rkv_pkg::STEP_WIDTH-1:0];
			end else begin
				pair_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cur_q[0] <= init_first_strain;
			cur_q[1] <= init_second_strain;
			cur_q[2] <= init_first_helper;
			cur_q[3] <= init_shared_pool;
			cur_q[4] <= init_first_complex;
			cur_q[5] <= init_second_complex;
		end
		if (ctl.issue && ctl.lanes && ctl.stage == rkv_pkg::LAST_STAGE && !ctl.pass) begin
			slope_q[ctl.lane] <= slope_fin;
		end
		if (ctl.wb && !ctl.lanes) begin
			if (uop.acc != rkv_pkg::ACC_NONE) begin
				acc_q <= acc_new;
			end
			case (uop.dst)
				rkv_pkg::DST_TU:  tu_q  <= wr_val;
				rkv_pkg::DST_TV:  tv_q  <= wr_val;
				rkv_pkg::DST_TB0: tb0_q <= wr_val;
				rkv_pkg::DST_TB1: tb1_q <= wr_val;
				rkv_pkg::DST_TP:  tp_q  <= wr_val;
				rkv_pkg::DST_K0:  k_q[0] <= wr_val;
				rkv_pkg::DST_K1:  k_q[1] <= wr_val;
				rkv_pkg::DST_K2:  k_q[2] <= wr_val;
				rkv_pkg::DST_K3:  k_q[3] <= wr_val;
				rkv_pkg::DST_K4:  k_q[4] <= wr_val;
				rkv_pkg::DST_K5:  k_q[5] <= wr_val;
				default: ;
			endcase
		end
		if (ctl.wb && ctl.lanes) begin
			if (ctl.stage != rkv_pkg::LAST_STAGE) begin
				probe_q[ctl.lane] <= rkv_pkg::sat_val(lane_sum);
				if (ctl.stage == 2'd0) begin
					slope_q[ctl.lane] <= SW'(k_q[ctl.lane]);
				end else begin
					slope_q[ctl.lane] <= slope_q[ctl.lane] + (SW'(k_q[ctl.lane]) <<< 1);
				end
			end else if (!ctl.pass) begin
				q_q <= unit_quot;
			end else begin
				cur_q[ctl.lane] <= rkv_pkg::sat_val(lane_sum);
			end
		end
		if (ctl.finish) begin
			for (int i = 0; i < NV; i++) begin
				out_q[i] <= cur_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign final_first_strain   = out_q[0];
	assign final_second_strain  = out_q[1];
	assign final_first_helper   = out_q[2];
	assign final_shared_pool    = out_q[3];
	assign final_first_complex  = out_q[4];
	assign final_second_complex = out_q[5];

endmodule

/* sv/rkv_mul_unit.sv */
// Shared multiply, round and saturate unit of the two-strain RK4 core.
// Depends on rkv_pkg.
module rkv_mul_unit (
	input  logic                                   clk,
	input  logic [rkv_pkg::MUL_WIDTH-1:0]          a_mag,
	input  logic [rkv_pkg::MUL_WIDTH-1:0]          b_mag,
	input  logic                                   neg,
	input  rkv_pkg::mul_mode_t                     mode,
	output logic signed [rkv_pkg::VALUE_WIDTH-1:0] res,
	output logic [rkv_pkg::MUL_WIDTH-1:0]          quot
);

	logic [rkv_pkg::PROD_WIDTH-1:0] prod_s1;
	logic                           neg_s1;
	rkv_pkg::mul_mode_t             mode_s1;

	logic [rkv_pkg::PROD_WIDTH-1:0] rnd;
	logic [rkv_pkg::PROD_WIDTH-1:0] sum;
	logic [rkv_pkg::PROD_WIDTH-1:0] shifted;
	logic [rkv_pkg::PROD_WIDTH-1:0] lim;
	logic [rkv_pkg::PROD_WIDTH-1:0] clamp;

	always_ff @(posedge clk) begin
		prod_s1 <= a_mag * b_mag;
		neg_s1  <= neg;
		mode_s1 <= mode;
	end

	always_comb begin
		case (mode_s1)
			rkv_pkg::MODE_F:  rnd = rkv_pkg::PROD_WIDTH'(1) << (rkv_pkg::FRAC_BITS - 1);
			rkv_pkg::MODE_F1: rnd = rkv_pkg::PROD_WIDTH'(1) << rkv_pkg::FRAC_BITS;
			rkv_pkg::MODE_Q:  rnd = rkv_pkg::PROD_WIDTH'(3) << rkv_pkg::FRAC_BITS;
			default:          rnd = '0;
		endcase
		sum = prod_s1 + rnd;
		case (mode_s1)
			rkv_pkg::MODE_F1:   shifted = sum >> (rkv_pkg::FRAC_BITS + 1);
			rkv_pkg::MODE_DIV6: shifted = prod_s1 >> rkv_pkg::RECIP_SHIFT;
			default:            shifted = sum >> rkv_pkg::FRAC_BITS;
		endcase
		// A negative result may reach one further than a positive one.
		lim   = (rkv_pkg::PROD_WIDTH'(1) << (rkv_pkg::VALUE_WIDTH - 1))
		        - rkv_pkg::PROD_WIDTH'(!neg_s1);
		clamp = (shifted > lim) ? lim : shifted;
		res   = neg_s1 ? -rkv_pkg::VALUE_WIDTH'(clamp) : rkv_pkg::VALUE_WIDTH'(clamp);
		quot  = shifted[rkv_pkg::MUL_WIDTH-1:0];
	end

endmodule

/* sv/rkv_seq.sv */
// Sequencer of the two-strain RK4 core: run, stage, microcode and lane counters.
// Depends on rkv_pkg.
module rkv_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              out_free,
	input  logic [rkv_pkg::STEP_WIDTH-1:0]    step_count,
	output logic                              busy,
	output rkv_pkg::ctl_t                     ctl
);

	rkv_pkg::state_t                state_q, state_d;
	logic [4:0]                     pc_q, pc_d;
	logic                           lanes_q, lanes_d;
	logic [2:0]                     lane_q, lane_d;
	logic                           pass_q, pass_d;
	logic [1:0]                     stage_q, stage_d;
	logic [rkv_pkg::STEP_WIDTH-1:0] steps_q, steps_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rkv_pkg::ST_IDLE;
			pc_q    <= '0;
			lanes_q <= 1'b0;
			lane_q  <= '0;
			pass_q  <= 1'b0;
			stage_q <= '0;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			lanes_q <= lanes_d;
			lane_q  <= lane_d;
			pass_q  <= pass_d;
			stage_q <= stage_d;
			steps_q <= steps_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		lanes_d = lanes_q;
		lane_d  = lane_q;
		pass_d  = pass_q;
		stage_d = stage_q;
		steps_d = steps_q;
		ctl        = '0;
		ctl.lanes  = lanes_q;
		ctl.lane   = lane_q;
		ctl.pass   = pass_q;
		ctl.stage  = stage_q;
		ctl.pc     = pc_q;
		case (state_q)
			rkv_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					steps_d  = step_count;
					state_d  = rkv_pkg::ST_CHECK;
				end
			end
			rkv_pkg::ST_CHECK: begin
				if (steps_q == '0) begin
					state_d = rkv_pkg::ST_FINISH;
				end else begin
					stage_d = '0;
					pc_d    = '0;
					lanes_d = 1'b0;
					lane_d  = '0;
					pass_d  = 1'b0;
					state_d = rkv_pkg::ST_ISSUE;
				end
			end
			rkv_pkg::ST_ISSUE: begin
				ctl.issue = 1'b1;
				state_d   = rkv_pkg::ST_WB;
			end
			rkv_pkg::ST_WB: begin
				ctl.wb  = 1'b1;
				state_d = rkv_pkg::ST_ISSUE;
				if (!lanes_q) begin
					if (pc_q == 5'(rkv_pkg::NUM_UOPS - 1)) begin
						lanes_d = 1'b1;
						lane_d  = '0;
					end else begin
						pc_d = pc_q + 5'd1;
					end
				end else if (stage_q == rkv_pkg::LAST_STAGE && !pass_q) begin
					// The final update takes a second pass for the division by six.
					pass_d = 1'b1;
				end else begin
					pass_d = 1'b0;
					if (lane_q != 3'(rkv_pkg::NUM_VARS - 1)) begin
						lane_d = lane_q + 3'd1;
					end else if (stage_q != rkv_pkg::LAST_STAGE) begin
						stage_d = stage_q + 2'd1;
						lanes_d = 1'b0;
						pc_d    = '0;
					end else begin
						steps_d = steps_q - 1'b1;
						state_d = rkv_pkg::ST_CHECK;
					end
				end
			end
			rkv_pkg::ST_FINISH: begin
				if (out_free) begin
					ctl.finish = 1'b1;
					state_d    = rkv_pkg::ST_IDLE;
				end
			end
			default: state_d = rkv_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != rkv_pkg::ST_IDLE);

endmodule

/* sv/rkv_checker.sv */
// Port-level checks for the two-strain RK4 core, bound to the top level.
// Depends on rkv_pkg and rk4_two_strain_virus_ode_core.
module rkv_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [rkv_pkg::IO_WIDTH-1:0] final_first_strain
);

	// A result beat held back by the receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(final_first_strain))
		else $error("output payload changed while stalled");

	// Once a beat is taken the core is busy with it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core took no notice of an accepted beat");

	// A result only appears at the end of a run.
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a run");

endmodule

bind rk4_two_strain_virus_ode_core rkv_checker u_rkv_checker (.*);

/* tb/sv/rk4_ode_checker.sv */
`timescale 1ns / 1ps
// Checker for the two-strain virus RK4 core: mirrors the register writes, predicts
// the final state of every accepted input beat and compares each output beat.
// Depends on rkv_pkg for the register indexes and widths.
module rk4_ode_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [rkv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rkv_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] init_first_strain,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] init_second_strain,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] init_first_helper,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] init_shared_pool,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] init_first_complex,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] init_second_complex,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] final_first_strain,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] final_second_strain,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] final_first_helper,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] final_shared_pool,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] final_first_complex,
	input  logic signed [rkv_pkg::IO_WIDTH-1:0] final_second_complex,
	output int                                 pending,
	output int                                 errors
);

	typedef longint state_vec_t [6];
	typedef struct {
		logic [rkv_pkg::IO_WIDTH-1:0] v [6];
	} final_state_t;

	logic [rkv_pkg::CFG_DATA_W-1:0] rate_pair [6];
	logic [23:0]                    step_h;
	logic [15:0]                    step_n;
	final_state_t                   expected_finals [$];

	function automatic longint clamp(input longint x, input int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
	endfunction

	function automatic longint mag_of(input longint x);
		return x < 0 ? -x : x;
	endfunction

	// Exact product, rounded half away from zero, clamped to the value range.
	function automatic longint round_mul(input longint a, input longint b, input int sh);
		logic [127:0] p;
		longint       lim;
		bit           neg;
		neg = (a < 0) != (b < 0);
		p = 128'(mag_of(a)) * 128'(mag_of(b)) + (128'(1) << (sh - 1));
		p = p >> sh;
		lim = (longint'(1) << (rkv_pkg::VALUE_WIDTH - 1)) - (neg ? 0 : 1);
		if (p > 128'(lim))
			p = 128'(lim);
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint rate_of(input int i);
		return longint'((rate_pair[i / 2] >> ((i % 2) * rkv_pkg::RATE_BITS)) & 48'hFF_FFFF);
	endfunction

	function automatic state_vec_t slopes_at(input state_vec_t x);
		state_vec_t f;
		longint     one, u, v, b0, b1;
		int         fb, vw;
		fb = rkv_pkg::FRAC_BITS;
		vw = rkv_pkg::VALUE_WIDTH;
		one = clamp(longint'(1) << fb, vw);
		u = clamp(one - x[0] - x[1], vw);
		v = clamp(one - x[2] - x[3], vw);
		b0 = round_mul(round_mul(rate_of(8), x[0], fb), x[3], fb);
		b1 = round_mul(round_mul(rate_of(9), x[1], fb), x[3], fb);
		f[0] = clamp(round_mul(round_mul(round_mul(rate_of(0), x[0], fb), x[2],
			fb), u, fb) - b0 - round_mul(rate_of(4), x[0], fb), vw);
		f[1] = clamp(round_mul(round_mul(round_mul(rate_of(1), x[1], fb), x[2],
			fb), u, fb) - b1 - round_mul(rate_of(5), x[1], fb), vw);
		f[2] = clamp(round_mul(round_mul(rate_of(2), x[0], fb), v, fb)
			- round_mul(rate_of(6), x[2], fb), vw);
		f[3] = clamp(round_mul(round_mul(rate_of(3), x[1], fb), v, fb)
			- round_mul(rate_of(7), x[3], fb), vw);
		f[4] = clamp(b0 - round_mul(rate_of(10), x[4], fb), vw);
		f[5] = clamp(b1 - round_mul(rate_of(11), x[5], fb), vw);
		return f;
	endfunction

	function automatic final_state_t integrate(input state_vec_t start);
		state_vec_t   cur, k, probe, acc;
		final_state_t r;
		longint       h, lim, q;
		logic [127:0] p;
		bit           neg;
		int           fb, vw;
		fb = rkv_pkg::FRAC_BITS;
		vw = rkv_pkg::VALUE_WIDTH;
		h = longint'(step_h);
		cur = start;
		for (int s = 0; s < step_n; s++) begin
			k = slopes_at(cur);
			for (int i = 0; i < 6; i++) begin
				acc[i] = k[i];
				probe[i] = clamp(cur[i] + round_mul(h, k[i], fb + 1), vw);
			end
			k = slopes_at(probe);
			for (int i = 0; i < 6; i++) begin
				acc[i] += 2 * k[i];
				probe[i] = clamp(cur[i] + round_mul(h, k[i], fb + 1), vw);
			end
			k = slopes_at(probe);
			for (int i = 0; i < 6; i++) begin
				acc[i] += 2 * k[i];
				probe[i] = clamp(cur[i] + round_mul(h, k[i], fb), vw);
			end
			k = slopes_at(probe);
			for (int i = 0; i < 6; i++) begin
				acc[i] = clamp(acc[i] + k[i], rkv_pkg::SLOPE_WIDTH);
				// Division by six after a rounding offset of half of six.
				p = 128'(mag_of(acc[i])) * 128'(h) + (128'(3) << fb);
				p = (p >> fb) / 6;
				neg = acc[i] < 0;
				lim = (longint'(1) << (vw - 1)) - (neg ? 0 : 1);
				q = (p > 128'(lim)) ? lim : longint'(p[63:0]);
				cur[i] = clamp(cur[i] + (neg ? -q : q), vw);
			end
		end
		for (int i = 0; i < 6; i++)
			r.v[i] = cur[i][rkv_pkg::IO_WIDTH-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what,
	                               input logic [rkv_pkg::IO_WIDTH-1:0] got,
	                               input logic [rkv_pkg::IO_WIDTH-1:0] want);
		$display("%0t: %s mismatch: got %0d expected %0d", $realtime, what,
			$signed(got), $signed(want));
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		state_vec_t   start;
		final_state_t want, got;
		string        names [6];
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				rate_pair[i] <= '0;
			step_h <= rkv_pkg::STEP_SIZE_RESET;
			step_n <= rkv_pkg::STEP_COUNT_RESET;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					rkv_pkg::CFG_STEP_SIZE:  step_h <= cfg_data[23:0];
					rkv_pkg::CFG_STEP_COUNT: step_n <= cfg_data[15:0];
					default:                 rate_pair[cfg_index] <= cfg_data;
				endcase
			end
			if (in_valid && !in_stall) begin
				start = '{init_first_strain, init_second_strain, init_first_helper,
					init_shared_pool, init_first_complex, init_second_complex};
				expected_finals.push_back(integrate(start));
			end
			if (out_valid && !out_stall) begin
				got.v = '{final_first_strain, final_second_strain, final_first_helper,
					final_shared_pool, final_first_complex, final_second_complex};
				names = '{"final_first_strain", "final_second_strain", "final_first_helper",
					"final_shared_pool", "final_first_complex", "final_second_complex"};
				if (expected_finals.size() == 0) begin
					$display("%0t: output beat with no input beat outstanding", $realtime);
					errors++;
				end else begin
					want = expected_finals.pop_front();
					for (int i = 0; i < 6; i++)
						if (got.v[i] !== want.v[i])
							report_mismatch(names[i], got.v[i], want.v[i]);
				end
			end
			pending = expected_finals.size();
		end
	end

endmodule

/* tb/sv/tb_rk4_two_strain_virus_ode_core.sv */
`timescale 1ns / 1ps
// Top of the testbench for the two-strain virus RK4 core: clock, reset, register
// phases, input beats, receiver stalls and the verdict. Depends on rkv_pkg, the core
// and rk4_ode_checker.
module tb_rk4_two_strain_virus_ode_core;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_write_en;
	logic [rkv_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [rkv_pkg::CFG_DATA_W-1:0]       cfg_data;
	logic                                 in_valid, in_stall, out_valid, out_stall;
	logic signed [rkv_pkg::IO_WIDTH-1:0]  init_val [6];
	logic signed [rkv_pkg::IO_WIDTH-1:0]  final_val [6];
	int                                   pending, errors;
	bit                                   calm;
	bit                                   hold_req;
	logic [rkv_pkg::CFG_DATA_W-1:0]       pairs [6];

	rk4_two_strain_virus_ode_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.init_first_strain(init_val[0]), .init_second_strain(init_val[1]),
		.init_first_helper(init_val[2]), .init_shared_pool(init_val[3]),
		.init_first_complex(init_val[4]), .init_second_complex(init_val[5]),
		.out_valid(out_valid), .out_stall(out_stall),
		.final_first_strain(final_val[0]), .final_second_strain(final_val[1]),
		.final_first_helper(final_val[2]), .final_shared_pool(final_val[3]),
		.final_first_complex(final_val[4]), .final_second_complex(final_val[5])
	);

	rk4_ode_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.init_first_strain(init_val[0]), .init_second_strain(init_val[1]),
		.init_first_helper(init_val[2]), .init_shared_pool(init_val[3]),
		.init_first_complex(init_val[4]), .init_second_complex(init_val[5]),
		.out_valid(out_valid), .out_stall(out_stall),
		.final_first_strain(final_val[0]), .final_second_strain(final_val[1]),
		.final_first_helper(final_val[2]), .final_shared_pool(final_val[3]),
		.final_first_complex(final_val[4]), .final_second_complex(final_val[5]),
		.pending(pending), .errors(errors)
	);

	always #4 clk = ~clk;

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stalls, or one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_req) begin
			out_stall <= 1'b1;
			repeat (4000) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 14);
		end
	end

	// Writes every register; the write enable stays high across the burst.
	task automatic configure(input logic [23:0] h, input logic [15:0] n);
		for (int i = 0; i < 8; i++) begin
			cfg_write_en <= 1'b1;
			cfg_index    <= rkv_pkg::CFG_IDX_W'(i);
			if (i == rkv_pkg::CFG_STEP_SIZE)
				cfg_data <= {24'($urandom), h};
			else if (i == rkv_pkg::CFG_STEP_COUNT)
				cfg_data <= {32'($urandom), n};
			else
				cfg_data <= pairs[i];
			@(posedge clk);
		end
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [rkv_pkg::CFG_DATA_W-1:0] modest_pair();
		return {24'($urandom_range(0, 2 << rkv_pkg::FRAC_BITS)),
			24'($urandom_range(0, 2 << rkv_pkg::FRAC_BITS))};
	endfunction

	function automatic logic signed [rkv_pkg::IO_WIDTH-1:0] pick_value();
		case ($urandom_range(9))
			0:       return 24'sh7F_FFFF;
			1:       return 24'sh80_0000;
			2, 3:    return 24'($urandom);
			default: return 24'($urandom_range(0, 1 << rkv_pkg::FRAC_BITS));
		endcase
	endfunction

	task automatic send_beat(input logic signed [rkv_pkg::IO_WIDTH-1:0] v [6]);
		if (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		for (int i = 0; i < 6; i++)
			init_val[i] <= v[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		logic signed [rkv_pkg::IO_WIDTH-1:0] v [6];
		for (int j = 0; j < count; j++) begin
			for (int i = 0; i < 6; i++)
				v[i] = pick_value();
			send_beat(v);
		end
	endtask

	// Lets the core finish every outstanding beat before the registers change.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic signed [rkv_pkg::IO_WIDTH-1:0] v [6];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		for (int i = 0; i < 6; i++)
			init_val[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: zero rates, so the state must come back unchanged.
		v = '{24'sh10_0000, -24'sd5, 24'sh7F_FFFF, 24'sh80_0000, 24'sd1, 24'sh05_5555};
		send_beat(v);
		drain();

		// Zero step count returns the initial values.
		for (int i = 0; i < 6; i++)
			pairs[i] = modest_pair();
		configure(24'd104858, 16'd0);
		v = '{24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF,
			24'sh7F_FFFF};
		send_beat(v);
		v = '{24'sh80_0000, 24'sh80_0000, 24'sh80_0000, 24'sh80_0000, 24'sh80_0000,
			24'sh80_0000};
		send_beat(v);
		drain();

		// Largest rates and step: saturation everywhere.
		for (int i = 0; i < 6; i++)
			pairs[i] = '1;
		configure(24'hFF_FFFF, 16'd1);
		send_beat(v);
		v = '{24'sh7F_FFFF, 24'sh80_0000, 24'sh7F_FFFF, 24'sh80_0000, 24'sh7F_FFFF,
			24'sh80_0000};
		send_beat(v);
		v = '{24'sh08_0000, 24'sh04_0000, 24'sh0C_0000, 24'sh02_0000, 24'sh01_0000, 24'sd0};
		send_beat(v);
		send_random(3);
		drain();

		// Zero step size with moderate rates.
		for (int i = 0; i < 6; i++)
			pairs[i] = modest_pair();
		configure(24'd0, 16'd2);
		send_random(3);
		drain();

		// Default step count with a realistic model.
		configure(24'd104858, 16'd100);
		v = '{24'sh01_0000, 24'sh00_8000, 24'sh08_0000, 24'sh04_0000, 24'sd0, 24'sd0};
		send_beat(v);
		send_random(2);
		drain();

		// Random phases; one runs without idling, one under a long receiver hold-off.
		for (int phase = 0; phase < 10; phase++) begin
			for (int i = 0; i < 6; i++)
				pairs[i] = ($urandom_range(3) == 0)
				           ? rkv_pkg::CFG_DATA_W'({$urandom, $urandom})
				           : modest_pair();
			configure(($urandom_range(3) == 0)
			          ? 24'($urandom)
			          : 24'($urandom_range(0, 1 << rkv_pkg::FRAC_BITS)),
				16'($urandom_range(1, 6)));
			calm = (phase == 3);
			if (phase == 6)
				hold_req = 1'b1;
			send_random(10);
			drain();
		end
		calm = 1'b0;

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
